>>> rtl/hjbp_pkg.sv
// Shared types and constants for the bucket-chained hash join block.
// No dependencies; used by every module of the block.
package hjbp_pkg;

    localparam int MAX_TUPLES_DEF  = 4096;
    localparam int MAX_BUCKETS_DEF = 4096;

    localparam int TUPLE_W = 64;
    localparam int OP_W    = 2;
    localparam int SHIFT_W = 6;
    localparam int BBITS_W = 4;
    localparam int MATCH_W = 13;
    localparam int TOTAL_W = 64;
    // raw bucket index before reduction: bucket_bits can reach 15
    localparam int IDX_W   = 15;
    localparam int RSTEP_W = 5;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [BBITS_W-1:0] BUCKET_BITS_RST = 4'd12;

    // operation codes; the fourth code changes nothing
    localparam logic [OP_W-1:0] OP_BUILD = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_KEY_SHIFT   = 2'd0;
    localparam logic [1:0] REG_HASH_SHIFT  = 2'd1;
    localparam logic [1:0] REG_BUCKET_BITS = 2'd2;

    typedef struct packed {
        logic accept;
        logic hash;
        logic red_step;
        logic clear;
        logic build_wr;
        logic walk_start;
        logic walk;
        logic out_load;
        logic init_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            drop;
        logic            need_red;
        logic            red_last;
        logic            head_ok;
        logic            walk_more;
        logic            init_last;
    } dp_stat_t;

endpackage

>>> rtl/hash_join_build_probe.sv
// From acceptance to result register: build runs hash, head read and head write;
// clear, no-op and dropped build run hash only; probe runs hash, head read and a
// chain walk. Reduction steps follow hash when MAX_BUCKETS is not a power of 2.
// One word in flight; the next is accepted the cycle after the result is registered.
// Reset is asynchronous and clears count, total, registers and handshake; then a
// pass over all bucket heads zeroes them before the first word is accepted.
module hash_join_build_probe #(
    parameter int MAX_TUPLES  = hjbp_pkg::MAX_TUPLES_DEF,
    parameter int MAX_BUCKETS = hjbp_pkg::MAX_BUCKETS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hjbp_pkg::APB_AW-1:0]   paddr,
    input  logic [hjbp_pkg::APB_DW-1:0]   pwdata,
    output logic [hjbp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hjbp_pkg::OP_W-1:0]     operation,
    input  logic [hjbp_pkg::TUPLE_W-1:0]  tuple_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [hjbp_pkg::MATCH_W-1:0]  item_matches,
    output logic [hjbp_pkg::TOTAL_W-1:0]  total_matches
);
    import hjbp_pkg::*;

    logic [SHIFT_W-1:0] key_shift_reg;
    logic [SHIFT_W-1:0] hash_shift_reg;
    logic [BBITS_W-1:0] bucket_bits_reg;
    logic               reg_wr;
    logic [1:0]         reg_idx;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_shift_reg   <= '0;
            hash_shift_reg  <= '0;
            bucket_bits_reg <= BUCKET_BITS_RST;
        end
        else if (reg_wr)
        begin
            unique case (reg_idx)
                REG_KEY_SHIFT:   key_shift_reg   <= pwdata[SHIFT_W-1:0];
                REG_HASH_SHIFT:  hash_shift_reg  <= pwdata[SHIFT_W-1:0];
                REG_BUCKET_BITS: bucket_bits_reg <= pwdata[BBITS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY_SHIFT:   prdata = APB_DW'(key_shift_reg);
            REG_HASH_SHIFT:  prdata = APB_DW'(hash_shift_reg);
            REG_BUCKET_BITS: prdata = APB_DW'(bucket_bits_reg);
            default:         prdata = '0;
        endcase
    end

    hjbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hjbp_dp #(
        .MAX_TUPLES  (MAX_TUPLES),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .tuple_value   (tuple_value),
        .key_shift     (key_shift_reg),
        .hash_shift    (hash_shift_reg),
        .bucket_bits   (bucket_bits_reg),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .item_matches  (item_matches),
        .total_matches (total_matches)
    );

`ifndef NO_ASSERTIONS
    // one word at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again while a word is in progress");

    // a dropped build reports no matches
    a_drop_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> item_matches == '0)
        else $error("dropped build reports matches");

    // a new result only appears after the block has been busy
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work in progress");
`endif

endmodule

>>> rtl/hjbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Uses hjbp_pkg for its parameter defaults.
module hjbp_ram #(
    parameter int WIDTH = hjbp_pkg::TUPLE_W,
    parameter int DEPTH = hjbp_pkg::MAX_TUPLES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/hjbp_ctrl.sv
// Sequencer for the hash join block: steps one word through hash, build or
// chain walk, and hands the result to the output register. Uses hjbp_pkg.
module hjbp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output hjbp_pkg::dp_cmd_t  cmd,
    input  hjbp_pkg::dp_stat_t stat
);
    import hjbp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HASH   = 4'd1;
    localparam logic [3:0] S_RED    = 4'd2;
    localparam logic [3:0] S_BHEAD  = 4'd3;
    localparam logic [3:0] S_BWRITE = 4'd4;
    localparam logic [3:0] S_PHEAD  = 4'd5;
    localparam logic [3:0] S_PFIRST = 4'd6;
    localparam logic [3:0] S_PWALK  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_INIT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                // zero every bucket head once after reset
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash = 1'b1;
                priority if (stat.op == OP_BUILD && !stat.drop)
                begin
                    state_next = stat.need_red ? S_RED : S_BHEAD;
                end
                else if (stat.op == OP_PROBE)
                begin
                    state_next = stat.need_red ? S_RED : S_PHEAD;
                end
                else
                begin
                    cmd.clear  = (stat.op == OP_CLEAR);
                    state_next = S_DONE;
                end
            end
            S_RED:
            begin
                cmd.red_step = 1'b1;
                if (stat.red_last)
                begin
                    state_next = (stat.op == OP_BUILD) ? S_BHEAD : S_PHEAD;
                end
            end
            S_BHEAD:
            begin
                state_next = S_BWRITE;
            end
            S_BWRITE:
            begin
                cmd.build_wr = 1'b1;
                state_next   = S_DONE;
            end
            S_PHEAD:
            begin
                state_next = S_PFIRST;
            end
            S_PFIRST:
            begin
                cmd.walk_start = 1'b1;
                state_next     = stat.head_ok ? S_PWALK : S_DONE;
            end
            S_PWALK:
            begin
                cmd.walk = 1'b1;
                if (!stat.walk_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/hjbp_dp.sv
// Datapath of the hash join block: bucket hash and reduction, bucket head,
// tuple and link memories, match counting and the output register.
// Uses hjbp_pkg and hjbp_ram.
module hjbp_dp #(
    parameter int MAX_TUPLES  = hjbp_pkg::MAX_TUPLES_DEF,
    parameter int MAX_BUCKETS = hjbp_pkg::MAX_BUCKETS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hjbp_pkg::OP_W-1:0]     operation,
    input  logic [hjbp_pkg::TUPLE_W-1:0]  tuple_value,
    input  logic [hjbp_pkg::SHIFT_W-1:0]  key_shift,
    input  logic [hjbp_pkg::SHIFT_W-1:0]  hash_shift,
    input  logic [hjbp_pkg::BBITS_W-1:0]  bucket_bits,
    input  hjbp_pkg::dp_cmd_t             cmd,
    output hjbp_pkg::dp_stat_t            stat,
    output logic                          status,
    output logic [hjbp_pkg::MATCH_W-1:0]  item_matches,
    output logic [hjbp_pkg::TOTAL_W-1:0]  total_matches
);
    import hjbp_pkg::*;

    localparam int AW     = $clog2(MAX_TUPLES);
    localparam int LW     = $clog2(MAX_TUPLES + 1);
    localparam int BW     = $clog2(MAX_BUCKETS);
    localparam int LINK_W = BW + LW;
    localparam bit POW2   = ((MAX_BUCKETS & (MAX_BUCKETS - 1)) == 0);
    // restoring reduction steps for a bucket count that is not a power of two
    localparam int RED_STEPS = (POW2 || MAX_BUCKETS >= (1 << IDX_W)) ? 0 :
                               IDX_W + 1 - $clog2(MAX_BUCKETS);
    localparam logic [LW-1:0]      MAX_COUNT = LW'(MAX_TUPLES);
    localparam logic [MATCH_W-1:0] MATCH_MAX = {MATCH_W{1'b1}};
    localparam logic [RSTEP_W-1:0] STEP_INIT = RSTEP_W'(RED_STEPS > 0 ? RED_STEPS - 1 : 0);
    localparam logic [BW-1:0]      INIT_LAST = BW'(MAX_BUCKETS - 1);

    logic [OP_W-1:0]    op_reg;
    logic [TUPLE_W-1:0] value_reg;
    logic [TUPLE_W-1:0] key_mask_reg;
    logic               drop_reg;
    logic [IDX_W-1:0]   rem_reg;
    logic [RSTEP_W-1:0] step_reg;
    logic [LW-1:0]      cnt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [MATCH_W-1:0] match_reg;
    logic [LW-1:0]      cur_reg;
    logic               out_status_reg;
    logic [MATCH_W-1:0] out_match_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [BW-1:0]      init_reg;

    logic [TUPLE_W-1:0] hash_word;
    logic [IDX_W-1:0]   idx_mask;
    logic [IDX_W-1:0]   idx_raw;
    logic [31:0]        rem_wide;
    logic [31:0]        divisor;
    logic [31:0]        rem_sub;
    logic [31:0]        bucket_wide;
    logic [BW-1:0]      bucket;

    logic [LW-1:0]      head_rd;
    logic [BW-1:0]      head_waddr;
    logic [LW-1:0]      head_wdata;
    logic [TUPLE_W-1:0] tuple_rd;
    logic [LINK_W-1:0]  link_rd;
    logic [BW-1:0]      link_tag;
    logic [LW-1:0]      link_next;
    logic [LW-1:0]      head_m1;
    logic [LW-1:0]      next_m1;
    logic [AW-1:0]      rd_addr;
    logic               tag_ok;
    logic               key_hit;
    logic               walk_more;

    // bucket index: value bits from hash_shift up, bucket_bits wide
    assign hash_word = value_reg >> hash_shift;
    assign idx_mask  = ~({IDX_W{1'b1}} << bucket_bits);
    assign idx_raw   = hash_word[IDX_W-1:0] & idx_mask;

    assign rem_wide    = 32'(rem_reg);
    assign divisor     = 32'(MAX_BUCKETS) << step_reg;
    assign rem_sub     = rem_wide - divisor;
    assign bucket_wide = POW2 ? (rem_wide & 32'(MAX_BUCKETS - 1)) : rem_wide;
    assign bucket      = bucket_wide[BW-1:0];

    assign link_tag  = link_rd[LINK_W-1:LW];
    assign link_next = link_rd[LW-1:0];
    assign head_m1   = head_rd - LW'(1);
    assign next_m1   = link_next - LW'(1);
    assign rd_addr   = cmd.walk_start ? head_m1[AW-1:0] : next_m1[AW-1:0];

    assign head_waddr = cmd.init_wr ? init_reg : bucket;
    assign head_wdata = cmd.init_wr ? '0 : cnt_reg + LW'(1);

    // a link is trusted only if it points below the current entry into a slot
    // filled since the last clear and tagged with this bucket
    assign tag_ok    = (link_tag == bucket);
    assign key_hit   = (((tuple_rd ^ value_reg) & key_mask_reg) == '0);
    assign walk_more = tag_ok && (link_next != '0) && (link_next < cur_reg);

    assign stat.op        = op_reg;
    assign stat.drop      = drop_reg;
    assign stat.need_red  = (RED_STEPS != 0);
    assign stat.red_last  = (step_reg == '0);
    assign stat.head_ok   = (head_rd != '0) && (head_rd <= cnt_reg);
    assign stat.walk_more = walk_more;
    assign stat.init_last = (init_reg == INIT_LAST);

    hjbp_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (cmd.build_wr || cmd.init_wr),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bucket),
        .rdata (head_rd)
    );

    hjbp_ram #(
        .WIDTH (TUPLE_W),
        .DEPTH (MAX_TUPLES)
    ) u_tuple_ram (
        .clk   (clk),
        .we    (cmd.build_wr),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (value_reg),
        .raddr (rd_addr),
        .rdata (tuple_rd)
    );

    hjbp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_TUPLES)
    ) u_link_ram (
        .clk   (clk),
        .we    (cmd.build_wr),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({bucket, head_rd}),
        .raddr (rd_addr),
        .rdata (link_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
        end
        else if (cmd.init_wr)
        begin
            init_reg <= init_reg + BW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            priority if (cmd.clear)
            begin
                cnt_reg   <= '0;
                total_reg <= '0;
            end
            else if (cmd.build_wr)
            begin
                cnt_reg <= cnt_reg + LW'(1);
            end
            else if (cmd.walk && tag_ok && key_hit)
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= operation;
            value_reg    <= tuple_value;
            key_mask_reg <= {TUPLE_W{1'b1}} << key_shift;
            drop_reg     <= (operation == OP_BUILD) && (cnt_reg == MAX_COUNT);
            match_reg    <= '0;
        end
        else if (cmd.walk && tag_ok && key_hit && match_reg != MATCH_MAX)
        begin
            match_reg <= match_reg + MATCH_W'(1);
        end

        if (cmd.hash)
        begin
            rem_reg  <= idx_raw;
            step_reg <= STEP_INIT;
        end
        else if (cmd.red_step)
        begin
            if (rem_wide >= divisor)
            begin
                rem_reg <= rem_sub[IDX_W-1:0];
            end
            step_reg <= step_reg - RSTEP_W'(1);
        end

        if (cmd.walk_start)
        begin
            cur_reg <= head_rd;
        end
        else if (cmd.walk && walk_more)
        begin
            cur_reg <= link_next;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= drop_reg;
            out_match_reg  <= match_reg;
            out_total_reg  <= total_reg;
        end
    end

    assign status        = out_status_reg;
    assign item_matches  = out_match_reg;
    assign total_matches = out_total_reg;

endmodule
